[hw/rtl/emsd_pkg.sv]
package emsd_pkg;

   // Request commands
   localparam logic [1:0] CMD_REF     = 2'd0;
   localparam logic [1:0] CMD_TGT     = 2'd1;
   localparam logic [1:0] CMD_CORRECT = 2'd2;
   localparam logic [1:0] CMD_CLEAR   = 2'd3;

   // Register indexes
   localparam logic CSR_CHANNELS = 1'b0;
   localparam logic CSR_STRENGTH = 1'b1;

   // Fixed datapath widths, the standard deviation floor and the lane count
   localparam int DIV_W      = 64;
   localparam int DIV_CNT_W  = 6;
   localparam int DEN_W      = 32;
   localparam int NUM_W      = 48;
   localparam int MEAN_W     = 24;
   localparam int EX2_W      = 32;
   localparam int STD_W      = 24;
   localparam int RAW_W      = 34;
   localparam int SQRT_IN_W  = 48;
   localparam int SQRT_CNT_W = 5;
   localparam int GAIN_W     = 37;
   localparam int BIAS_W     = 44;
   localparam int STD_FLOOR  = 66;
   localparam int LANES      = 4;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCUM,
      OP_CLEAR,
      OP_LATCH,
      OP_DIV_START,
      OP_DIV_WAIT,
      OP_VAR,
      OP_SQRT_START,
      OP_SQRT_WAIT,
      OP_MUL1,
      OP_MUL2,
      OP_STORE,
      OP_RESULT
   } dp_op_type;

   typedef enum logic [1:0] {
      DK_MEAN,
      DK_EX2,
      DK_RAW
   } div_kind_type;

   typedef struct packed {
      dp_op_type    op;
      logic         side;
      div_kind_type kind;
      logic [1:0]   chan;
   } dp_cmd_type;

   typedef struct packed {
      logic any_empty;
      logic out_full;
      logic div_done;
      logic sqrt_done;
   } dp_status_type;

endpackage

[hw/rtl/exposure_match_mean_std_top.sv]
// Exposure matching by per-channel mean and standard deviation.
// Request channel (req_valid/req_ready): cmd 0 adds the pixel to the
// reference statistics, cmd 1 to the target statistics, cmd 3 clears both,
// cmd 2 asks for the corrected pixel. Only cmd 2 returns a transaction on
// the response channel (rsp_valid/rsp_ready). Register writes come on the
// csr channel (index 0 channels in use, index 1 match strength); the user
// must write only while idle; the block itself does not enforce this.
// Accumulate and clear take one pixel per cycle while no response waits.
// A correction with current coefficients registers its response via S_OUT.
// The first correction after new statistics or a new strength recomputes
// the coefficients of all MAX_CHANNELS channels: per channel five 64-step
// divisions on the shared divider and two 24-step square roots.
// A pending response blocks new requests until rsp_ready takes it; a
// stalled receiver therefore holds req_ready low.
// Reset (synchronous) clears all sums and counts, sets channels in use to 3
// and strength to 4096, and marks the coefficients stale.
module exposure_match_mean_std_top #(
   parameter int MAX_CHANNELS = 4,
   parameter int COUNT_BITS   = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_sample_0,
   input  logic [7:0]  req_sample_1,
   input  logic [7:0]  req_sample_2,
   input  logic [7:0]  req_sample_3,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_0,
   output logic [7:0]  rsp_out_1,
   output logic [7:0]  rsp_out_2,
   output logic [7:0]  rsp_out_3,
   output logic        rsp_passed_unchanged,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   emsd_pkg::dp_cmd_type            cmd;
   emsd_pkg::dp_status_type         status;
   logic [emsd_pkg::LANES-1:0][7:0] sample;
   logic [emsd_pkg::LANES-1:0][7:0] rsp_px;
   logic                            csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;
   assign sample    = {req_sample_3, req_sample_2, req_sample_1, req_sample_0};

   emsd_ctrl #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_cmd     (req_cmd),
      .req_ready   (req_ready),
      .strength_we (csr_we && (csr_index == emsd_pkg::CSR_STRENGTH)),
      .status      (status),
      .cmd         (cmd)
   );

   emsd_dp #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .sample     (sample),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_px     (rsp_px),
      .rsp_passed (rsp_passed_unchanged)
   );

   assign rsp_out_0 = rsp_px[0];
   assign rsp_out_1 = rsp_px[1];
   assign rsp_out_2 = rsp_px[2];
   assign rsp_out_3 = rsp_px[3];

   // A correct request keeps the block busy in the following cycle
   a_correct_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == emsd_pkg::CMD_CORRECT) |=> !req_ready)
      else $error("request taken right after a correct transaction");

   // Accumulate and clear never produce a response
   a_no_rsp_accum: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd != emsd_pkg::CMD_CORRECT) |=> !rsp_valid)
      else $error("response after a non-correct transaction");

   // A fresh response blocks new requests
   a_rsp_blocks: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_ready)
      else $error("request ready while a new response is pending");

endmodule

[hw/rtl/emsd_div.sv]
module emsd_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [emsd_pkg::DIV_W-1:0]   dividend,
   input  logic [emsd_pkg::DEN_W-1:0]   divisor,
   output logic                         done,
   output logic [emsd_pkg::DIV_W-1:0]   quotient
);

   logic [emsd_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [emsd_pkg::DEN_W-1:0]     rem_ff, rem_in;
   logic [emsd_pkg::DEN_W-1:0]     den_ff, den_in;
   logic [emsd_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [emsd_pkg::DEN_W:0]       rem_t;
   logic                           ge;

   // One restoring step per cycle, quotient bits shift in from the right
   always_comb begin
      rem_t   = {rem_ff, quo_ff[emsd_pkg::DIV_W-1]};
      ge      = rem_t >= {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = '1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[emsd_pkg::DIV_W-2:0], ge};
         rem_in = ge ? emsd_pkg::DEN_W'(rem_t - {1'b0, den_ff})
                     : emsd_pkg::DEN_W'(rem_t);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hw/rtl/emsd_sqrt.sv]
module emsd_sqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [emsd_pkg::SQRT_IN_W-1:0]   radicand,
   output logic                             done,
   output logic [emsd_pkg::STD_W-1:0]       root
);

   logic [emsd_pkg::SQRT_IN_W-1:0]  x_ff, x_in;
   logic [emsd_pkg::STD_W+1:0]      rem_ff, rem_in;
   logic [emsd_pkg::STD_W-1:0]      root_ff, root_in;
   logic [emsd_pkg::SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [emsd_pkg::STD_W+3:0]      rem_t;
   logic [emsd_pkg::STD_W+3:0]      trial;
   logic                            ge;

   // Digit-by-digit root, two radicand bits per cycle
   always_comb begin
      rem_t   = {rem_ff, x_ff[emsd_pkg::SQRT_IN_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      ge      = rem_t >= trial;
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = emsd_pkg::SQRT_CNT_W'(emsd_pkg::STD_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in    = {x_ff[emsd_pkg::SQRT_IN_W-3:0], 2'b00};
         rem_in  = ge ? (emsd_pkg::STD_W+2)'(rem_t - trial)
                      : (emsd_pkg::STD_W+2)'(rem_t);
         root_in = {root_ff[emsd_pkg::STD_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[hw/rtl/emsd_ctrl.sv]
module emsd_ctrl #(
   parameter int MAX_CHANNELS = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_cmd,
   output logic                    req_ready,
   input  logic                    strength_we,
   input  emsd_pkg::dp_status_type status,
   output emsd_pkg::dp_cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_DSTART = 9'b000000010,
      S_DWAIT  = 9'b000000100,
      S_VAR    = 9'b000001000,
      S_QSTART = 9'b000010000,
      S_QWAIT  = 9'b000100000,
      S_MUL1   = 9'b001000000,
      S_MUL2   = 9'b010000000,
      S_OUT    = 9'b100000000
   } state_type;

   state_type              state_ff, state_in;
   logic [1:0]             chan_ff, chan_in;
   logic                   side_ff, side_in;
   emsd_pkg::div_kind_type kind_ff, kind_in;
   logic                   ready_ff, ready_in;
   logic                   store_ff, store_in;

   always_comb begin
      state_in  = state_ff;
      chan_in   = chan_ff;
      side_in   = side_ff;
      kind_in   = kind_ff;
      ready_in  = ready_ff;
      store_in  = 1'b0;
      cmd.op    = emsd_pkg::OP_NONE;
      cmd.side  = side_ff;
      cmd.kind  = kind_ff;
      cmd.chan  = chan_ff;
      req_ready = (state_ff == S_IDLE) && !store_ff && !status.out_full;
      // a new strength invalidates the coefficients
      if (strength_we) begin
         ready_in = 1'b0;
      end
      // write back coefficients of the channel just finished
      if (store_ff) begin
         cmd.op = emsd_pkg::OP_STORE;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               case (req_cmd)
                  emsd_pkg::CMD_REF, emsd_pkg::CMD_TGT: begin
                     cmd.op   = emsd_pkg::OP_ACCUM;
                     cmd.side = (req_cmd == emsd_pkg::CMD_TGT);
                     ready_in = 1'b0;
                  end
                  emsd_pkg::CMD_CLEAR: begin
                     cmd.op   = emsd_pkg::OP_CLEAR;
                     ready_in = 1'b0;
                  end
                  default: begin
                     cmd.op = emsd_pkg::OP_LATCH;
                     if (status.any_empty || ready_ff) begin
                        state_in = S_OUT;
                     end else begin
                        chan_in  = '0;
                        side_in  = 1'b0;
                        kind_in  = emsd_pkg::DK_MEAN;
                        state_in = S_DSTART;
                     end
                  end
               endcase
            end
         end
         S_DSTART: begin
            if (!store_ff) begin
               cmd.op   = emsd_pkg::OP_DIV_START;
               state_in = S_DWAIT;
            end
         end
         S_DWAIT: begin
            cmd.op = emsd_pkg::OP_DIV_WAIT;
            if (status.div_done) begin
               case (kind_ff)
                  emsd_pkg::DK_MEAN: begin
                     kind_in  = emsd_pkg::DK_EX2;
                     state_in = S_DSTART;
                  end
                  emsd_pkg::DK_EX2: state_in = S_VAR;
                  default:          state_in = S_MUL1;
               endcase
            end
         end
         S_VAR: begin
            cmd.op   = emsd_pkg::OP_VAR;
            state_in = S_QSTART;
         end
         S_QSTART: begin
            cmd.op   = emsd_pkg::OP_SQRT_START;
            state_in = S_QWAIT;
         end
         S_QWAIT: begin
            cmd.op = emsd_pkg::OP_SQRT_WAIT;
            if (status.sqrt_done) begin
               if (!side_ff) begin
                  side_in = 1'b1;
                  kind_in = emsd_pkg::DK_MEAN;
               end else begin
                  kind_in = emsd_pkg::DK_RAW;
               end
               state_in = S_DSTART;
            end
         end
         S_MUL1: begin
            cmd.op   = emsd_pkg::OP_MUL1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.op   = emsd_pkg::OP_MUL2;
            store_in = 1'b1;
            // advance to the next channel or finish the run
            if (chan_ff == 2'(MAX_CHANNELS - 1)) begin
               ready_in = 1'b1;
               state_in = S_OUT;
            end else begin
               chan_in  = chan_ff + 1'b1;
               side_in  = 1'b0;
               kind_in  = emsd_pkg::DK_MEAN;
               state_in = S_DSTART;
            end
         end
         S_OUT: begin
            if (!store_ff) begin
               cmd.op   = emsd_pkg::OP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // the store uses the channel of the previous cycle
      if (store_ff) begin
         cmd.chan = chan_ff - 1'b1;
         if (state_ff == S_OUT) begin
            cmd.chan = chan_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      chan_ff <= chan_in;
      side_ff <= side_in;
      kind_ff <= kind_in;
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
         store_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         store_ff <= store_in;
      end
   end

endmodule

[hw/rtl/emsd_dp.sv]
module emsd_dp #(
   parameter int MAX_CHANNELS = 4,
   parameter int COUNT_BITS   = 24
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  emsd_pkg::dp_cmd_type                      cmd,
   output emsd_pkg::dp_status_type                   status,
   input  logic [emsd_pkg::LANES-1:0][7:0]           sample,
   input  logic                                      csr_we,
   input  logic                                      csr_index,
   input  logic [15:0]                               csr_wdata,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic [emsd_pkg::LANES-1:0][7:0]           rsp_px,
   output logic                                      rsp_passed
);

   localparam int SUM_W = COUNT_BITS + 8;
   localparam int SQ_W  = COUNT_BITS + 16;
   localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   logic [SUM_W-1:0]      ref_sum_ff [MAX_CHANNELS];
   logic [SUM_W-1:0]      tgt_sum_ff [MAX_CHANNELS];
   logic [SQ_W-1:0]       ref_sq_ff  [MAX_CHANNELS];
   logic [SQ_W-1:0]       tgt_sq_ff  [MAX_CHANNELS];
   logic [COUNT_BITS-1:0] ref_cnt_ff, tgt_cnt_ff;

   logic signed [emsd_pkg::GAIN_W-1:0] gain_ff [MAX_CHANNELS];
   logic signed [emsd_pkg::BIAS_W-1:0] bias_ff [MAX_CHANNELS];

   logic [2:0]         chans_ff;
   logic signed [15:0] strength_ff;

   logic [emsd_pkg::LANES-1:0][7:0] px_ff;
   logic [emsd_pkg::LANES-1:0][7:0] out_ff;
   logic [7:0]                      out_in [emsd_pkg::LANES];
   logic                            valid_ff;
   logic                            passed_ff;

   logic [emsd_pkg::MEAN_W-1:0] rm_ff, tm_ff;
   logic [emsd_pkg::EX2_W-1:0]  ex2_ff;
   logic [emsd_pkg::EX2_W-1:0]  var_ff;
   logic [emsd_pkg::STD_W-1:0]  rs_ff, ts_ff;
   logic [emsd_pkg::RAW_W-1:0]  raw_ff;
   logic signed [51:0]          p1_ff;
   logic [57:0]                 p2_ff;
   logic signed [40:0]          g_ff;
   logic signed [60:0]          p3_ff;

   logic [CH_W-1:0]            ch;
   logic                       count_full;
   logic                       any_empty;
   logic [emsd_pkg::NUM_W-1:0] div_num;
   logic [emsd_pkg::DEN_W-1:0] div_den;
   logic                       div_done;
   logic [emsd_pkg::DIV_W-1:0] div_quo;
   logic                       sqrt_done;
   logic [emsd_pkg::STD_W-1:0] sqrt_root;
   logic [emsd_pkg::STD_W-1:0] std_val;
   logic [47:0]                m_sq;
   logic [emsd_pkg::EX2_W-1:0] m2;
   logic signed [35:0]         raw_diff;
   logic signed [44:0]         mean_diff;
   logic signed [48:0]         bias_full;
   logic [2:0]                 nch;

   assign ch        = cmd.chan[CH_W-1:0];
   assign any_empty = (ref_cnt_ff == '0) || (tgt_cnt_ff == '0);
   assign count_full = cmd.side ? (tgt_cnt_ff == '1) : (ref_cnt_ff == '1);

   // Select divider operands
   always_comb begin
      case (cmd.kind)
         emsd_pkg::DK_MEAN:
            div_num = cmd.side ? emsd_pkg::NUM_W'(tgt_sum_ff[ch])
                               : emsd_pkg::NUM_W'(ref_sum_ff[ch]);
         emsd_pkg::DK_EX2:
            div_num = cmd.side ? emsd_pkg::NUM_W'(tgt_sq_ff[ch])
                               : emsd_pkg::NUM_W'(ref_sq_ff[ch]);
         default:
            div_num = emsd_pkg::NUM_W'(rs_ff);
      endcase
      if (cmd.kind == emsd_pkg::DK_RAW) begin
         div_den = emsd_pkg::DEN_W'(ts_ff);
      end else begin
         div_den = cmd.side ? emsd_pkg::DEN_W'(tgt_cnt_ff) : emsd_pkg::DEN_W'(ref_cnt_ff);
      end
   end

   emsd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == emsd_pkg::OP_DIV_START),
      .dividend ({div_num, 16'b0}),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   emsd_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == emsd_pkg::OP_SQRT_START),
      .radicand ({var_ff, 16'b0}),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // Coefficient arithmetic
   always_comb begin
      m_sq      = rm_ff * rm_ff;
      if (cmd.side) begin
         m_sq = tm_ff * tm_ff;
      end
      m2        = m_sq[47:16];
      std_val   = (sqrt_root < emsd_pkg::STD_W'(emsd_pkg::STD_FLOOR))
                  ? emsd_pkg::STD_W'(emsd_pkg::STD_FLOOR) : sqrt_root;
      raw_diff  = $signed({2'b00, raw_ff}) - 36'sd65536;
      mean_diff = $signed({21'b0, rm_ff}) - $signed({3'b000, p2_ff[57:16]});
      bias_full = p3_ff[60:12];
   end

   // Statistics and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            ref_sum_ff[c] <= '0;
            tgt_sum_ff[c] <= '0;
            ref_sq_ff[c]  <= '0;
            tgt_sq_ff[c]  <= '0;
         end
         ref_cnt_ff  <= '0;
         tgt_cnt_ff  <= '0;
         chans_ff    <= 3'd3;
         strength_ff <= 16'sd4096;
      end else begin
         if (csr_we) begin
            if (csr_index == emsd_pkg::CSR_CHANNELS) begin
               chans_ff <= csr_wdata[2:0];
            end else begin
               strength_ff <= $signed(csr_wdata);
            end
         end
         if (cmd.op == emsd_pkg::OP_CLEAR) begin
            for (int c = 0; c < MAX_CHANNELS; c++) begin
               ref_sum_ff[c] <= '0;
               tgt_sum_ff[c] <= '0;
               ref_sq_ff[c]  <= '0;
               tgt_sq_ff[c]  <= '0;
            end
            ref_cnt_ff <= '0;
            tgt_cnt_ff <= '0;
         end else if (cmd.op == emsd_pkg::OP_ACCUM && !count_full) begin
            // add one pixel to the selected set
            for (int c = 0; c < MAX_CHANNELS; c++) begin
               if (cmd.side) begin
                  tgt_sum_ff[c] <= tgt_sum_ff[c] + SUM_W'(sample[c]);
                  tgt_sq_ff[c]  <= tgt_sq_ff[c]
                                   + SQ_W'(16'(sample[c]) * 16'(sample[c]));
               end else begin
                  ref_sum_ff[c] <= ref_sum_ff[c] + SUM_W'(sample[c]);
                  ref_sq_ff[c]  <= ref_sq_ff[c]
                                   + SQ_W'(16'(sample[c]) * 16'(sample[c]));
               end
            end
            if (cmd.side) begin
               tgt_cnt_ff <= tgt_cnt_ff + 1'b1;
            end else begin
               ref_cnt_ff <= ref_cnt_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         emsd_pkg::OP_LATCH: px_ff <= sample;
         emsd_pkg::OP_DIV_WAIT: begin
            if (div_done) begin
               case (cmd.kind)
                  emsd_pkg::DK_MEAN: begin
                     if (cmd.side) tm_ff <= div_quo[emsd_pkg::MEAN_W-1:0];
                     else          rm_ff <= div_quo[emsd_pkg::MEAN_W-1:0];
                  end
                  emsd_pkg::DK_EX2: ex2_ff <= div_quo[emsd_pkg::EX2_W-1:0];
                  default:          raw_ff <= div_quo[emsd_pkg::RAW_W-1:0];
               endcase
            end
         end
         emsd_pkg::OP_VAR: var_ff <= (ex2_ff > m2) ? (ex2_ff - m2) : '0;
         emsd_pkg::OP_SQRT_WAIT: begin
            if (sqrt_done) begin
               if (cmd.side) ts_ff <= std_val;
               else          rs_ff <= std_val;
            end
         end
         emsd_pkg::OP_MUL1: begin
            p1_ff <= strength_ff * raw_diff;
            p2_ff <= tm_ff * raw_ff;
         end
         emsd_pkg::OP_MUL2: begin
            g_ff  <= $signed({p1_ff[51], p1_ff[51:12]}) + 41'sd65536;
            p3_ff <= strength_ff * mean_diff;
         end
         emsd_pkg::OP_STORE: begin
            // saturate gain and bias to their stored widths
            if (g_ff[40:36] == {5{g_ff[36]}}) begin
               gain_ff[ch] <= g_ff[36:0];
            end else begin
               gain_ff[ch] <= {g_ff[40], {(emsd_pkg::GAIN_W-1){~g_ff[40]}}};
            end
            if (bias_full[48:43] == {6{bias_full[43]}}) begin
               bias_ff[ch] <= bias_full[43:0];
            end else begin
               bias_ff[ch] <= {bias_full[48], {(emsd_pkg::BIAS_W-1){~bias_full[48]}}};
            end
         end
         default: ;
      endcase
   end

   // Effective channel count
   always_comb begin
      if (chans_ff == 3'd0) begin
         nch = 3'd1;
      end else if (chans_ff > 3'(MAX_CHANNELS)) begin
         nch = 3'(MAX_CHANNELS);
      end else begin
         nch = chans_ff;
      end
   end

   // Map each lane through gain and bias, or pass it unchanged when a set is empty or the lane is not in use
   for (genvar c = 0; c < emsd_pkg::LANES; c++) begin : g_lane
      if (c < MAX_CHANNELS) begin : g_match
         logic signed [45:0] prod;
         logic signed [46:0] x;
         logic [46:0]        xr;
         always_comb begin
            prod = $signed({1'b0, px_ff[c]}) * gain_ff[c];
            x    = 47'(prod) + 47'(bias_ff[c]);
            xr   = x + 47'sd32768;
            if (any_empty || (3'(c) >= nch)) begin
               out_in[c] = px_ff[c];
            end else if (x < 0) begin
               out_in[c] = 8'd0;
            end else if (x > 47'sd16711680) begin
               out_in[c] = 8'd255;
            end else begin
               out_in[c] = xr[23:16];
            end
         end
      end else begin : g_pass
         assign out_in[c] = px_ff[c];
      end
   end

   // Output register; hold until taken
   always_ff @(posedge clock) begin
      if (cmd.op == emsd_pkg::OP_RESULT) begin
         for (int c = 0; c < emsd_pkg::LANES; c++) begin
            out_ff[c] <= out_in[c];
         end
         passed_ff <= any_empty;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.op == emsd_pkg::OP_RESULT) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   assign status.any_empty = any_empty;
   assign status.out_full  = valid_ff;
   assign status.div_done  = div_done;
   assign status.sqrt_done = sqrt_done;
   assign rsp_valid  = valid_ff;
   assign rsp_px     = out_ff;
   assign rsp_passed = passed_ff;

endmodule

[test/tb_top.sv]
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCH       = 4;
   localparam int WD_LIMIT  = 20000;
   localparam int SETTLE    = 10;

   typedef struct {
      logic [3:0][7:0] pix;
      logic            passed;
   } pixel_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = emsd_pkg::CMD_CLEAR;
   logic [7:0]  req_sample_0 = '0;
   logic [7:0]  req_sample_1 = '0;
   logic [7:0]  req_sample_2 = '0;
   logic [7:0]  req_sample_3 = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_0, rsp_out_1, rsp_out_2, rsp_out_3;
   logic        rsp_passed_unchanged;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = emsd_pkg::CSR_CHANNELS;
   logic [15:0] csr_wdata = '0;

   exposure_match_mean_std_top dut (.*);

   always #2 clock = ~clock;

   // predictor state
   longint unsigned ref_s[NCH], ref_ss[NCH], tgt_s[NCH], tgt_ss[NCH];
   longint unsigned ref_n, tgt_n;
   longint          gain_q16[NCH], bias_q16[NCH];
   bit              coeff_ok;
   int unsigned     chan_cfg;
   longint          strength_q12;

   pixel_result_type expected_pixels[$];
   int unsigned     mismatches = 0;
   int unsigned     send_idle = 0, recv_idle = 0;
   int unsigned     hold_left = 0;
   int unsigned     quiet_cycles = 0;

   function automatic longint unsigned q16_div(longint unsigned num, longint unsigned den);
      longint unsigned q, r;
      q = num / den;
      r = num % den;
      return (q << 16) + ((r << 16) / den);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic void channel_moments(input longint unsigned s, input longint unsigned ss,
                                           input longint unsigned n,
                                           output longint unsigned mean,
                                           output longint unsigned sd);
      longint unsigned m, ex2, m2, r;
      m = q16_div(s, n);
      ex2 = q16_div(ss, n);
      m2 = (m * m) >> 16;
      mean = m;
      if (ex2 <= m2) begin
         sd = emsd_pkg::STD_FLOOR;
      end else begin
         r = int_sqrt((ex2 - m2) << 16);
         sd = (r < emsd_pkg::STD_FLOOR) ? emsd_pkg::STD_FLOOR : r;
      end
   endfunction

   function automatic longint clamp_signed(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim - 1) return -lim - 1;
      return v;
   endfunction

   // work out gain and bias of every lane from the current sums
   function automatic void derive_coeffs();
      longint unsigned rm, rs, tm, ts, raw;
      longint g, d, b;
      for (int c = 0; c < NCH; c++) begin
         channel_moments(ref_s[c], ref_ss[c], ref_n, rm, rs);
         channel_moments(tgt_s[c], tgt_ss[c], tgt_n, tm, ts);
         raw = q16_div(rs, ts);
         g = 65536 + ((strength_q12 * ($signed(raw) - 65536)) >>> 12);
         d = $signed(rm) - $signed((tm * raw) >> 16);
         b = (strength_q12 * d) >>> 12;
         gain_q16[c] = clamp_signed(g, (64'sd1 <<< 36) - 1);
         bias_q16[c] = clamp_signed(b, (64'sd1 <<< 43) - 1);
      end
      coeff_ok = 1'b1;
   endfunction

   function automatic void clear_stats();
      for (int c = 0; c < NCH; c++) begin
         ref_s[c] = 0; ref_ss[c] = 0; tgt_s[c] = 0; tgt_ss[c] = 0;
      end
      ref_n = 0;
      tgt_n = 0;
      coeff_ok = 1'b0;
   endfunction

   // update statistics for one accepted transaction, queue the corrected pixel
   function automatic void predict_pixel(logic [1:0] cmd, logic [3:0][7:0] px);
      pixel_result_type res;
      longint x;
      int unsigned nch;
      longint unsigned maxcnt;
      maxcnt = (64'd1 << 24) - 1;
      if (cmd == emsd_pkg::CMD_REF || cmd == emsd_pkg::CMD_TGT) begin
         for (int c = 0; c < NCH; c++) begin
            if (cmd == emsd_pkg::CMD_REF && ref_n < maxcnt) begin
               ref_s[c] += px[c];
               ref_ss[c] += px[c] * px[c];
            end
            if (cmd == emsd_pkg::CMD_TGT && tgt_n < maxcnt) begin
               tgt_s[c] += px[c];
               tgt_ss[c] += px[c] * px[c];
            end
         end
         if (cmd == emsd_pkg::CMD_REF && ref_n < maxcnt) ref_n++;
         if (cmd == emsd_pkg::CMD_TGT && tgt_n < maxcnt) tgt_n++;
         coeff_ok = 1'b0;
      end else if (cmd == emsd_pkg::CMD_CLEAR) begin
         clear_stats();
      end else begin
         res.pix = px;
         res.passed = 1'b1;
         if (ref_n != 0 && tgt_n != 0) begin
            res.passed = 1'b0;
            if (!coeff_ok) derive_coeffs();
            nch = (chan_cfg == 0) ? 1 : ((chan_cfg > NCH) ? NCH : chan_cfg);
            for (int c = 0; c < NCH; c++) begin
               if (c < nch) begin
                  x = $signed({56'd0, px[c]}) * gain_q16[c] + bias_q16[c];
                  if (x < 0) res.pix[c] = 8'd0;
                  else if (x > (64'sd255 <<< 16)) res.pix[c] = 8'd255;
                  else res.pix[c] = 8'((x + 32768) >>> 16);
               end
            end
         end
         expected_pixels = {expected_pixels, res};
      end
   endfunction

   // offer one pixel transaction and wait for its accept
   task automatic send_pixel(input logic [1:0] cmd, input logic [3:0][7:0] px);
      @(negedge clock);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      {req_sample_3, req_sample_2, req_sample_1, req_sample_0} <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_pixel(cmd, px);
   endtask

   task automatic drop_request();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // wait until every corrected pixel is back, then let the pipeline settle
   task automatic drain();
      drop_request();
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == emsd_pkg::CSR_CHANNELS) begin
         chan_cfg = data & 16'd7;
      end else begin
         strength_q12 = $signed(data);
         coeff_ok = 1'b0;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [3:0][7:0] rand_pixel(int unsigned lo, int unsigned hi);
      logic [3:0][7:0] px;
      for (int c = 0; c < NCH; c++) px[c] = $urandom_range(hi, lo);
      return px;
   endfunction

   // check each corrected pixel against the oldest expectation
   always @(posedge clock) begin
      pixel_result_type exp_px;
      logic [3:0][7:0] got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_out_3, rsp_out_2, rsp_out_1, rsp_out_0};
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            exp_px = expected_pixels.pop_front();
            if (got !== exp_px.pix || rsp_passed_unchanged !== exp_px.passed) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h/%b actual %h/%b",
                           exp_px.pix, exp_px.passed, got, rsp_passed_unchanged);
            end
         end
      end
   end

   // receiver: random stalls, plus long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // watchdog on cycles without any accepted transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WD_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic test_directed();
      send_pixel(emsd_pkg::CMD_CORRECT, {8'd255, 8'd0, 8'd255, 8'd0});
      send_pixel(emsd_pkg::CMD_REF, {8'd0, 8'd0, 8'd0, 8'd0});
      send_pixel(emsd_pkg::CMD_CORRECT, {8'd12, 8'd34, 8'd56, 8'd78});
      send_pixel(emsd_pkg::CMD_REF, {8'd255, 8'd255, 8'd255, 8'd255});
      send_pixel(emsd_pkg::CMD_TGT, {8'd100, 8'd100, 8'd100, 8'd100});
      send_pixel(emsd_pkg::CMD_TGT, {8'd100, 8'd100, 8'd100, 8'd100});
      send_pixel(emsd_pkg::CMD_CORRECT, {8'd0, 8'd100, 8'd200, 8'd255});
      send_pixel(emsd_pkg::CMD_CORRECT, {8'd255, 8'd99, 8'd101, 8'd0});
      send_pixel(emsd_pkg::CMD_TGT, {8'd0, 8'd255, 8'd0, 8'd255});
      send_pixel(emsd_pkg::CMD_CORRECT, {8'd128, 8'd128, 8'd128, 8'd128});
      write_reg(emsd_pkg::CSR_CHANNELS, 16'd4);
      send_pixel(emsd_pkg::CMD_CORRECT, {8'd1, 8'd254, 8'd127, 8'd128});
      write_reg(emsd_pkg::CSR_STRENGTH, 16'h8000);
      send_pixel(emsd_pkg::CMD_CORRECT, {8'd1, 8'd254, 8'd127, 8'd128});
      write_reg(emsd_pkg::CSR_STRENGTH, 16'h7fff);
      write_reg(emsd_pkg::CSR_CHANNELS, 16'd0);
      send_pixel(emsd_pkg::CMD_CORRECT, {8'd200, 8'd50, 8'd255, 8'd0});
      write_reg(emsd_pkg::CSR_CHANNELS, 16'd7);
      send_pixel(emsd_pkg::CMD_CORRECT, {8'd200, 8'd50, 8'd255, 8'd0});
      send_pixel(emsd_pkg::CMD_CLEAR, {8'd0, 8'd0, 8'd0, 8'd0});
      send_pixel(emsd_pkg::CMD_CORRECT, {8'd17, 8'd34, 8'd51, 8'd68});
      send_pixel(emsd_pkg::CMD_TGT, {8'd5, 8'd6, 8'd7, 8'd8});
      send_pixel(emsd_pkg::CMD_CORRECT, {8'd17, 8'd34, 8'd51, 8'd68});
      drain();
   endtask

   // clear, accumulate both sets, then correct a few pixels; also random register writes and noise bursts
   task automatic test_random_sets(input int unsigned n_items);
      int unsigned sent, lo, hi, nref, ntgt, ncor;
      logic [15:0] strengths[6];
      strengths = '{16'h8000, 16'h7fff, 16'h0000, 16'h1000, 16'h0800, 16'hf000};
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(3) == 0)
            write_reg(emsd_pkg::CSR_CHANNELS, 16'($urandom_range(7)));
         if ($urandom_range(3) == 0) begin
            if ($urandom_range(1))
               write_reg(emsd_pkg::CSR_STRENGTH, strengths[$urandom_range(5)]);
            else write_reg(emsd_pkg::CSR_STRENGTH, 16'($urandom));
         end
         if ($urandom_range(9) == 0) begin
            // noise: any command with any pixel
            repeat (6) begin
               send_pixel(2'($urandom_range(3)), rand_pixel(0, 255));
               sent++;
            end
         end else begin
            send_pixel(emsd_pkg::CMD_CLEAR, rand_pixel(0, 255));
            nref = $urandom_range(12, 1);
            ntgt = $urandom_range(12, 1);
            ncor = $urandom_range(8, 1);
            lo = $urandom_range(255);
            hi = $urandom_range(1) ? 255 : lo + $urandom_range(255 - lo, 0);
            for (int i = 0; i < nref; i++) send_pixel(emsd_pkg::CMD_REF, rand_pixel(lo, hi));
            lo = $urandom_range(255);
            hi = $urandom_range(1) ? lo : lo + $urandom_range(255 - lo, 0);
            for (int i = 0; i < ntgt; i++) send_pixel(emsd_pkg::CMD_TGT, rand_pixel(lo, hi));
            for (int i = 0; i < ncor; i++)
               send_pixel(emsd_pkg::CMD_CORRECT, rand_pixel(0, 255));
            sent += 1 + nref + ntgt + ncor;
         end
      end
      drain();
   endtask

   // hold the receiver off while corrections keep coming
   task automatic test_backpressure();
      send_pixel(emsd_pkg::CMD_REF, rand_pixel(0, 255));
      send_pixel(emsd_pkg::CMD_TGT, rand_pixel(0, 255));
      send_pixel(emsd_pkg::CMD_CORRECT, rand_pixel(0, 255));
      drain();
      @(negedge clock);
      hold_left = 300;
      repeat (20) send_pixel(emsd_pkg::CMD_CORRECT, rand_pixel(0, 255));
      drain();
   endtask

   initial begin
      chan_cfg = 3;
      strength_q12 = 4096;
      clear_stats();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      send_idle = 22; recv_idle = 56;
      test_directed();
      test_random_sets(300);
      test_backpressure();
      send_idle = 56; recv_idle = 22;
      test_random_sets(300);
      send_idle = 0; recv_idle = 0;
      test_random_sets(300);

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
